[sv/hsv_pkg.sv]
// shared types and constants for the hsv to rgb converter
package hsv_pkg;

   localparam int HueWidth = 9;
   localparam int PctWidth = 10;
   localparam int ChanWidth = 8;

   // products and channel numerators on a common denominator of 60,000,000
   localparam int ProdWidth = 20;
   localparam int NumWidth = 27;
   localparam int QuotWidth = 9;

   localparam logic [HueWidth-1:0] HueMax = 9'd360;
   localparam logic [15:0] ValScale = 16'd60000;
   localparam logic [5:0] SectorDeg = 6'd60;

   // floor(255*n/6e7) = floor(floor(17*n/256)/15625), 15625 by reciprocal
   localparam int ScaledWidth = 22;
   localparam int RecipWidth = 23;
   localparam logic [RecipWidth-1:0] RecipMul = 23'd4398047;
   localparam int RecipShift = 36;
   localparam int MulWidth = ScaledWidth + RecipWidth;

   typedef struct packed {
      logic [HueWidth-1:0] hue_deg;
      logic [PctWidth-1:0] sat_permille;
      logic [PctWidth-1:0] val_permille;
   } req_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red_out;
      logic [ChanWidth-1:0] green_out;
      logic [ChanWidth-1:0] blue_out;
   } rsp_type;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

endpackage

[sv/hsv_to_rgb_converter.sv]
// hsv to rgb pixel converter, five-stage pipeline
// Converts one pixel per clock: a request taken when start is high and busy is low
// shows its rgb result on rsp_data with rsp_valid high for one cycle; the receiver
// cannot stall the pipeline and must take every result.
// The pipeline stages are saturation times value, the secondary-component
// multiply, the 17/256 prescale, the reciprocal multiply for the 15625 divide, and
// the sector routing with clamp. busy is high only while reset is asserted. A hue
// above 360 returns black; saturation or value above 1000 clamp each channel to 0..255.
module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int Depth = 5;

   logic [Depth-1:0] valid_in;
   logic [Depth-1:0] valid_ff;

   // stage 1: v*s, v*60000, hue fold and sector
   logic [ProdWidth-1:0]  prod_in, prod_ff;
   logic [NumWidth-2:0]   vscaled_in, vscaled_ff;
   logic [HueWidth-1:0]   hue_mod_in;
   logic [HueWidth-1:0]   hue_dist_in;
   logic [5:0]            tdist_in, tdist_ff;
   sector_type            sector_in;
   sector_type            sector_ff [Depth-1];
   logic [Depth-2:0]      black_ff;

   // stage 2: channel numerators
   logic [NumWidth-2:0]          prod_t_in;
   logic [NumWidth-2:0]          prod_60_in;
   logic signed [NumWidth-1:0]   num_c_ff, num_x_ff, num_z_ff;

   logic [QuotWidth-1:0] quot_c, quot_x, quot_z;
   logic [ChanWidth-1:0] chan_c, chan_x, chan_z;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;

   assign busy = reset;

   assign valid_in = {valid_ff[Depth-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign prod_in    = ProdWidth'({10'd0, req_data.val_permille}
                     * {10'd0, req_data.sat_permille});
   assign vscaled_in = (NumWidth-1)'({16'd0, req_data.val_permille}
                     * {10'd0, ValScale});

   // hue mod 120 by compare and subtract, then |h mod 120 - 60|
   always_comb begin
      if (req_data.hue_deg >= 9'd240) begin
         hue_mod_in = req_data.hue_deg - 9'd240;
      end else if (req_data.hue_deg >= 9'd120) begin
         hue_mod_in = req_data.hue_deg - 9'd120;
      end else begin
         hue_mod_in = req_data.hue_deg;
      end
      if (hue_mod_in >= 9'd60) begin
         hue_dist_in = hue_mod_in - 9'd60;
      end else begin
         hue_dist_in = 9'd60 - hue_mod_in;
      end
      tdist_in = hue_dist_in[5:0];
   end

   // boundary degrees fall to the lower sector
   always_comb begin
      priority if (req_data.hue_deg <= 9'd60) begin
         sector_in = SEC_RED_YEL;
      end else if (req_data.hue_deg <= 9'd120) begin
         sector_in = SEC_YEL_GRN;
      end else if (req_data.hue_deg <= 9'd180) begin
         sector_in = SEC_GRN_CYN;
      end else if (req_data.hue_deg <= 9'd240) begin
         sector_in = SEC_CYN_BLU;
      end else if (req_data.hue_deg <= 9'd300) begin
         sector_in = SEC_BLU_MAG;
      end else begin
         sector_in = SEC_MAG_RED;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      vscaled_ff <= vscaled_in;
      tdist_ff   <= tdist_in;
      sector_ff[0] <= sector_in;
      black_ff[0]  <= (req_data.hue_deg > HueMax);
      for (int i = 1; i < Depth-1; i++) begin
         sector_ff[i] <= sector_ff[i-1];
         black_ff[i]  <= black_ff[i-1];
      end
   end

   // numerator is 60000*v - prod*w with w = 0, t or 60
   assign prod_t_in  = (NumWidth-1)'({6'd0, prod_ff} * {20'd0, tdist_ff});
   assign prod_60_in = (NumWidth-1)'({6'd0, prod_ff} * {20'd0, SectorDeg});

   always_ff @(posedge clock) begin
      num_c_ff <= $signed({1'b0, vscaled_ff});
      num_x_ff <= $signed({1'b0, vscaled_ff}) - $signed({1'b0, prod_t_in});
      num_z_ff <= $signed({1'b0, vscaled_ff}) - $signed({1'b0, prod_60_in});
   end

   hsv_scale u_scale_c (.clock(clock), .num(num_c_ff), .quot(quot_c));
   hsv_scale u_scale_x (.clock(clock), .num(num_x_ff), .quot(quot_x));
   hsv_scale u_scale_z (.clock(clock), .num(num_z_ff), .quot(quot_z));

   assign chan_c = (quot_c > QuotWidth'(255)) ? 8'hff : quot_c[ChanWidth-1:0];
   assign chan_x = (quot_x > QuotWidth'(255)) ? 8'hff : quot_x[ChanWidth-1:0];
   assign chan_z = (quot_z > QuotWidth'(255)) ? 8'hff : quot_z[ChanWidth-1:0];

   always_comb begin
      unique case (sector_ff[Depth-2])
         SEC_RED_YEL: rsp_in = '{red_out: chan_c, green_out: chan_x, blue_out: chan_z};
         SEC_YEL_GRN: rsp_in = '{red_out: chan_x, green_out: chan_c, blue_out: chan_z};
         SEC_GRN_CYN: rsp_in = '{red_out: chan_z, green_out: chan_c, blue_out: chan_x};
         SEC_CYN_BLU: rsp_in = '{red_out: chan_z, green_out: chan_x, blue_out: chan_c};
         SEC_BLU_MAG: rsp_in = '{red_out: chan_x, green_out: chan_z, blue_out: chan_c};
         SEC_MAG_RED: rsp_in = '{red_out: chan_c, green_out: chan_z, blue_out: chan_x};
         default:     rsp_in = '0;
      endcase
      if (black_ff[Depth-2]) begin
         rsp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_data  = rsp_ff;

endmodule

[sv/hsv_scale.sv]
// two-stage channel scaler: floor(255*num/60e6), negative numerators give zero
module hsv_scale
   import hsv_pkg::*;
(
   input  logic                        clock,
   input  logic signed [NumWidth-1:0]  num,
   output logic [QuotWidth-1:0]        quot
);

   logic [NumWidth+3:0]    times17_in;
   logic [ScaledWidth-1:0] scaled_in;
   logic [ScaledWidth-1:0] scaled_ff;
   logic [MulWidth-1:0]    mul_in;
   logic [MulWidth-1:0]    mul_ff;

   // 17*n then drop 8 bits, n fits 26 bits when positive
   assign times17_in = {1'b0, num[NumWidth-2:0], 4'b0000}
                     + {5'b00000, num[NumWidth-2:0]};
   assign scaled_in  = num[NumWidth-1] ? '0 : times17_in[ScaledWidth+7:8];

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

   assign mul_in = {{RecipWidth{1'b0}}, scaled_ff} * {{ScaledWidth{1'b0}}, RecipMul};

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
   end

   assign quot = mul_ff[RecipShift+QuotWidth-1:RecipShift];

endmodule

[sv/hsv_checker.sv]
// port-level checker for the hsv to rgb converter, bound to the top level
module hsv_checker
   import hsv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic accept;

   assign accept = start & ~busy;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("request not answered five cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result strobe without a matching request");

   a_black: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.hue_deg > HueMax) |-> ##5 (rsp_data == '0))
      else $error("hue above 360 did not give black");

   a_gray: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.sat_permille == '0) |-> ##5
      (rsp_data.red_out == rsp_data.green_out && rsp_data.green_out == rsp_data.blue_out))
      else $error("zero saturation did not give gray");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);
